/* rtl/core/compacting_id_set_core_macros.svh */
// assertion macros for the compacting id set core
`ifndef COMPACTING_ID_SET_CORE_MACROS_SVH
`define COMPACTING_ID_SET_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CIS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CIS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cis_pkg.sv */
// shared types and constants for the compacting id set core
package cis_pkg;

  // fixed field widths of the command and result ports
  localparam int IN_ID_W   = 32;
  localparam int POS_W     = 4;
  localparam int OUT_VAL_W = 32;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_HAS = 2'd2,
    OP_GET = 2'd3
  } cis_op_t;

  // scan token handed from one cell to the next lower one
  typedef struct packed {
    logic active;  // token sits at this point of the chain
    logic seen;    // a valid match was found at a higher position
  } cis_tok_t;

  // commit strobes broadcast to every cell
  typedef struct packed {
    logic load;   // append the key at position count
    logic shift;  // delete: marked cells take their upper neighbor
  } cis_cmd_t;

endpackage

/* rtl/core/compacting_id_set_core.sv */
// top level of the compacting id set: control, result registers, cell chain
//
//  channel   handshake                 fields
//  command   start in, busy out        opcode, item_id, position
//  result    done out (one cycle)      status, found, read_value, entry_count
//
// an item is taken when start is high and busy is low; its result strobes on
// done once the scan token has left the bottom cell, and the next item can
// be taken when busy drops together with done, so items do not overlap
// the scan token walks the cell chain from the top cell down, one cell a cycle
// reset clears the count and all control; entries hold nothing valid then
// results cannot be stalled: done is a one-cycle strobe
`include "compacting_id_set_core_macros.svh"

module compacting_id_set_core #(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 32,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [cis_pkg::IN_ID_W-1:0]   item_id,
  input  logic [cis_pkg::POS_W-1:0]     position,
  output logic                          done,
  output logic                          status,
  output logic                          found,
  output logic [cis_pkg::OUT_VAL_W-1:0] read_value,
  output logic [CNT_W-1:0]              entry_count
);

  // ids are kept in their low bits only
  localparam int KEY_W = (ID_WIDTH < cis_pkg::IN_ID_W) ? ID_WIDTH : cis_pkg::IN_ID_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                      state;
  logic                        launch;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  cis_pkg::cis_op_t            op;
  logic [KEY_W-1:0]            key;
  logic [cis_pkg::POS_W-1:0]   pos;
  logic                        accept;
  logic                        fin;
  logic                        key_zero;
  logic                        full;
  logic                        any_hit;
  logic                        status_next;
  logic                        found_next;
  logic [cis_pkg::OUT_VAL_W-1:0] value_next;
  cis_pkg::cis_cmd_t           cmd;

  cis_pkg::cis_tok_t           tok  [CAPACITY];
  logic [KEY_W-1:0]            data [CAPACITY];
  logic [KEY_W-1:0]            val  [CAPACITY];
  logic [CAPACITY-1:0]         tok_act;

  assign busy        = state != S_IDLE;
  assign accept      = start && !busy;
  assign entry_count = count;

  // operands held for the length of the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= cis_pkg::cis_op_t'(opcode);
      key <= item_id[KEY_W-1:0];
      pos <= position;
    end
  end

  // cell chain, token enters at the top and leaves at cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cis_pkg::cis_tok_t tok_up;
    logic [KEY_W-1:0]  data_up;
    logic [KEY_W-1:0]  val_up;

    if (i == CAPACITY - 1) begin : g_top
      assign tok_up.active = launch;
      assign tok_up.seen   = 1'b0;
      assign data_up       = '0;
      assign val_up        = '0;
    end else begin : g_mid
      assign tok_up  = tok[i+1];
      assign data_up = data[i+1];
      assign val_up  = val[i+1];
    end

    cis_cell #(
      .INDEX (i),
      .KEY_W (KEY_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .key      (key),
      .pos      (pos),
      .count    (count),
      .cmd      (cmd),
      .tok_in   (tok_up),
      .data_in  (data_up),
      .up_value (val_up),
      .tok_out  (tok[i]),
      .data_out (data[i]),
      .value    (val[i])
    );

    assign tok_act[i] = tok[i].active;
  end

  // result and commit once the token leaves the bottom cell
  assign fin      = (state == S_SCAN) && tok[0].active;
  assign any_hit  = tok[0].seen;
  assign key_zero = key == '0;
  assign full     = count == CNT_W'(CAPACITY);

  always_comb begin
    cmd         = '0;
    status_next = 1'b0;
    found_next  = 1'b0;
    value_next  = '0;
    count_next  = count;
    unique case (op)
      cis_pkg::OP_ADD: begin
        if (key_zero || full) begin
          status_next = 1'b1;
        end else begin
          cmd.load   = fin;
          count_next = count + CNT_W'(1);
        end
      end
      cis_pkg::OP_DEL: begin
        if (key_zero || !any_hit) begin
          status_next = 1'b1;
        end else begin
          cmd.shift  = fin;
          count_next = count - CNT_W'(1);
        end
      end
      cis_pkg::OP_HAS: begin
        if (key_zero) begin
          status_next = 1'b1;
        end else begin
          found_next = any_hit;
        end
      end
      cis_pkg::OP_GET: begin
        value_next = cis_pkg::OUT_VAL_W'(data[0]);
      end
      default: begin
        status_next = 1'b0;
      end
    endcase
  end

  // control state machine with the result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state  <= S_SCAN;
            launch <= 1'b1;
          end
        end
        S_SCAN: begin
          if (fin) begin
            state      <= S_IDLE;
            done       <= 1'b1;
            count      <= count_next;
            status     <= status_next;
            found      <= found_next;
            read_value <= value_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `CIS_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result strobe while still busy")
  `CIS_ASSERT_NXT(a_accept_busy, clk, rst, accept, busy, "accepted item did not start a scan")
  `CIS_ASSERT_NXT(a_count_hold, clk, rst, !fin, $stable(count), "count moved outside commit")
  `CIS_ASSERT_IMP(a_one_token, clk, rst, 1'b1, $onehot0(tok_act), "more than one scan token")

endmodule

/* rtl/core/cis_cell.sv */
// one storage cell of the id chain: entry, local compare, scan stage
module cis_cell #(
  parameter int INDEX = 0,
  parameter int KEY_W = 32,
  parameter int CNT_W = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [KEY_W-1:0]          key,
  input  logic [cis_pkg::POS_W-1:0] pos,
  input  logic [CNT_W-1:0]          count,
  input  cis_pkg::cis_cmd_t         cmd,
  input  cis_pkg::cis_tok_t         tok_in,
  input  logic [KEY_W-1:0]          data_in,
  input  logic [KEY_W-1:0]          up_value,
  output cis_pkg::cis_tok_t         tok_out,
  output logic [KEY_W-1:0]          data_out,
  output logic [KEY_W-1:0]          value
);

  // cells past the position field range are never addressed by get
  localparam bit POS_REACH = INDEX < (1 << cis_pkg::POS_W);

  logic live;
  logic hit_here;
  logic at_pos;
  logic at_tail;
  logic shift_sel;

  // local decode against the broadcast operands
  assign live     = count > CNT_W'(INDEX);
  assign hit_here = live && (value == key);
  assign at_pos   = POS_REACH && live && (pos == cis_pkg::POS_W'(INDEX));
  assign at_tail  = count == CNT_W'(INDEX);

  // token stage toward the lower neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.active <= tok_in.active;
      tok_out.seen   <= tok_in.active && (tok_in.seen || hit_here);
    end
  end

  // scan data, shift mark and the stored entry
  always_ff @(posedge clk) begin
    if (tok_in.active) begin
      data_out  <= at_pos ? value : data_in;
      shift_sel <= !tok_in.seen;
    end
    if (cmd.load && at_tail) begin
      value <= key;
    end else if (cmd.shift && shift_sel) begin
      value <= up_value;
    end
  end

endmodule
